// File: hdl/sct_pkg.sv
// Shared types, widths and codes for the moving-average crossover trader.
package sct_pkg;

  localparam int PRICE_W        = 32;
  localparam int WLEN_W         = 9;
  localparam int SHARE_W        = 47;
  localparam int CASH_W         = 48;
  localparam int WINDOW_MAX_DEF = 256;

  localparam logic [WLEN_W-1:0]  WLEN_RESET = WLEN_W'(20);
  localparam logic [SHARE_W-1:0] SHARE_MAX  = '1;
  localparam logic [CASH_W-1:0]  CASH_SAT   = '1;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam int IN_TDATA_W    = 32;
  localparam int OUT_DATA_BITS = SHARE_W + 2 * CASH_W;
  localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W   = 3;

  localparam int CMD_Q_AW = 1;

  typedef enum logic [1:0] {
    ACT_WARMUP = 2'd0,
    ACT_NONE   = 2'd1,
    ACT_BUY    = 2'd2,
    ACT_SELL   = 2'd3
  } action_t;

  typedef enum logic {
    REG_WINDOW_LEN = 1'b0,
    REG_INIT_BAL   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_DECIDE
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_BUY_FIN,
    B_MUL,
    B_SELL_FIN,
    B_PEAK,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    action_t            action;
    logic               liq;
  } cmd_t;

  typedef struct packed {
    logic              clear;
    logic [WLEN_W-1:0] len;
  } win_cfg_t;

  typedef struct packed {
    logic              load;
    logic [CASH_W-1:0] value;
  } bal_cfg_t;

endpackage

// File: hdl/sma_crossover_trader.sv
// Top level of the moving-average crossover trader: register port, front end, queue, engine.
//
//   Port group  Direction  Carries
//   in_         slave      one closing price per transaction, tlast marks the final day
//   out_        master     one trading result per price
//   cfg_        APB        window length (0x0) and starting cash (0x8)
//
// The front end takes a price through acceptance, ring read with scaling, then the decision.
// The engine passes a step with no trade straight to the result, a buy through a 48-step
// divider, a sale through a 32-step multiplier, a buy liquidated the same day through both.
// Reset is synchronous and clears the window, position, cash and peak; no clearing pass.
// A stalled result register holds the engine; the queue lets the front end run two ahead.
module sma_crossover_trader #(
  parameter int WINDOW_MAX = sct_pkg::WINDOW_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sct_pkg::IN_TDATA_W-1:0]  in_tdata,   // price[31:0]
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sct_pkg::OUT_TDATA_W-1:0] out_tdata,  // shares_held, balance, highest_balance
  output logic [sct_pkg::OUT_TUSER_W-1:0] out_tuser,  // action[1:0], liquidated
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sct_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [sct_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [sct_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import sct_pkg::*;

  logic [WLEN_W-1:0]  window_len_r;
  logic [CASH_W-1:0]  init_bal_r;
  logic               cfg_wr;
  reg_idx_t           reg_idx;
  win_cfg_t           win_cfg;
  bal_cfg_t           bal_cfg;

  cmd_t               push_cmd, head_cmd;
  logic               cmd_push, cmd_full, cmd_pop, cmd_empty;

  logic [1:0]         res_action;
  logic [SHARE_W-1:0] res_shares;
  logic [CASH_W-1:0]  res_balance, res_highest;
  logic               res_liq;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = reg_idx_t'(cfg_paddr[3]);

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_LEN: cfg_prdata = CFG_DATA_W'(window_len_r);
      REG_INIT_BAL:   cfg_prdata = CFG_DATA_W'(init_bal_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WLEN_RESET;
      init_bal_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WINDOW_LEN: window_len_r <= cfg_pwdata[WLEN_W-1:0];
        REG_INIT_BAL:   init_bal_r   <= cfg_pwdata[CASH_W-1:0];
        default:        ;
      endcase
    end
  end

  assign win_cfg.clear = cfg_wr & (reg_idx == REG_WINDOW_LEN);
  assign win_cfg.len   = window_len_r;
  assign bal_cfg.load  = cfg_wr & (reg_idx == REG_INIT_BAL);
  assign bal_cfg.value = cfg_pwdata[CASH_W-1:0];

  sct_front #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_price (in_tdata[PRICE_W-1:0]),
    .in_last  (in_tlast),
    .win_cfg  (win_cfg),
    .cmd_push (cmd_push),
    .cmd      (push_cmd),
    .cmd_full (cmd_full)
  );

  sct_cmd_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (push_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (head_cmd),
    .empty (cmd_empty)
  );

  sct_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_empty   (cmd_empty),
    .cmd_pop     (cmd_pop),
    .cmd         (head_cmd),
    .bal_cfg     (bal_cfg),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_action  (res_action),
    .out_shares  (res_shares),
    .out_balance (res_balance),
    .out_highest (res_highest),
    .out_liq     (res_liq)
  );

  assign out_tdata = {(OUT_TDATA_W - OUT_DATA_BITS)'(0), res_highest, res_balance, res_shares};
  assign out_tuser = {res_liq, res_action};

endmodule

// File: hdl/sct_front.sv
// Front end: accepts prices, maintains the price window and classifies each trading step.
module sct_front #(
  parameter int WINDOW_MAX = sct_pkg::WINDOW_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sct_pkg::PRICE_W-1:0] in_price,
  input  logic                        in_last,
  input  sct_pkg::win_cfg_t           win_cfg,
  output logic                        cmd_push,
  output sct_pkg::cmd_t               cmd,
  input  logic                        cmd_full
);
  import sct_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int SUM_W = PRICE_W + $clog2(WINDOW_MAX + 1);
  localparam int SCL_W = PRICE_W + WLEN_W;
  localparam int CMP_W = (SUM_W > SCL_W) ? SUM_W : SCL_W;
  localparam int IDX_W = ((PTR_W > WLEN_W) ? PTR_W : WLEN_W) + 1;

  front_state_t state_r, state_nxt;

  logic [PRICE_W-1:0] price_r;
  logic               last_r;
  logic [PRICE_W-1:0] ring [WINDOW_MAX];
  logic [PRICE_W-1:0] old_price_r;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt, old_idx;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [WLEN_W-1:0]  fill_r, fill_nxt, win_n;
  logic               hold_r, hold_nxt;
  logic [SCL_W-1:0]   scaled_r;
  logic [IDX_W-1:0]   ptr_x, n_x, old_x;
  logic               accept, load_scaled, commit;
  logic               warm, below, above, buy, sell, hold_mid, liq;
  action_t            act;

  always_comb begin
    if (win_cfg.len == '0) begin
      win_n = WLEN_W'(1);
    end else if (int'(win_cfg.len) > WINDOW_MAX) begin
      win_n = WLEN_W'(WINDOW_MAX);
    end else begin
      win_n = win_cfg.len;
    end
  end

  always_comb begin
    ptr_x = IDX_W'(ptr_r);
    n_x   = IDX_W'(win_n);
    if (ptr_x >= n_x) begin
      old_x = ptr_x - n_x;
    end else begin
      old_x = ptr_x + IDX_W'(WINDOW_MAX) - n_x;
    end
    old_idx = old_x[PTR_W-1:0];
  end

  always_comb begin
    warm  = fill_r < win_n;
    below = CMP_W'(scaled_r) < CMP_W'(sum_r);
    above = CMP_W'(scaled_r) > CMP_W'(sum_r);
    buy   = !warm && !hold_r && below && (price_r != '0);
    sell  = !warm && hold_r && above;
    priority if (warm) begin
      act = ACT_WARMUP;
    end else if (buy) begin
      act = ACT_BUY;
    end else if (sell) begin
      act = ACT_SELL;
    end else begin
      act = ACT_NONE;
    end
    hold_mid = buy | (hold_r & ~sell);
    liq      = last_r & hold_mid;
    hold_nxt = hold_mid & ~liq;
    if (warm) begin
      sum_nxt  = sum_r + SUM_W'(price_r);
      fill_nxt = fill_r + WLEN_W'(1);
    end else begin
      sum_nxt  = sum_r - SUM_W'(old_price_r) + SUM_W'(price_r);
      fill_nxt = fill_r;
    end
    if (ptr_r == PTR_W'(WINDOW_MAX - 1)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_r + PTR_W'(1);
    end
  end

  always_comb begin
    unique case (state_r)
      F_IDLE:   state_nxt = in_valid ? F_READ : F_IDLE;
      F_READ:   state_nxt = F_DECIDE;
      F_DECIDE: state_nxt = cmd_full ? F_DECIDE : F_IDLE;
      default:  state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == F_IDLE);
    accept      = in_ready & in_valid;
    load_scaled = (state_r == F_READ);
    commit      = (state_r == F_DECIDE) & ~cmd_full;
    cmd_push    = commit;
    cmd.price   = price_r;
    cmd.action  = act;
    cmd.liq     = liq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      ptr_r   <= '0;
      sum_r   <= '0;
      fill_r  <= '0;
      hold_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (win_cfg.clear) begin
        ptr_r  <= '0;
        sum_r  <= '0;
        fill_r <= '0;
      end else if (commit) begin
        ptr_r  <= ptr_nxt;
        sum_r  <= sum_nxt;
        fill_r <= fill_nxt;
      end
      if (commit) begin
        hold_r <= hold_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      price_r <= in_price;
      last_r  <= in_last;
    end
    if (load_scaled) begin
      scaled_r <= SCL_W'(price_r) * SCL_W'(win_n);
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      ring[ptr_r] <= price_r;
    end
    if (load_scaled) begin
      old_price_r <= ring[old_idx];
    end
  end

endmodule

// File: hdl/sct_cmd_fifo.sv
// Two-entry command queue between the front end and the trade engine.
module sct_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sct_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output sct_pkg::cmd_t dout,
  output logic          empty
);
  import sct_pkg::*;

  localparam int DEPTH = 1 << CMD_Q_AW;

  cmd_t                mem [DEPTH];
  logic [CMD_Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_Q_AW:0]   count_r;
  logic                do_push, do_pop;

  assign full    = (count_r == (CMD_Q_AW + 1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CMD_Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CMD_Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (CMD_Q_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (CMD_Q_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

// File: hdl/sct_back.sv
// Trade engine: serial divide for buys, serial multiply for sales, and the result register.
module sct_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  input  sct_pkg::cmd_t               cmd,
  input  sct_pkg::bal_cfg_t           bal_cfg,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_action,
  output logic [sct_pkg::SHARE_W-1:0] out_shares,
  output logic [sct_pkg::CASH_W-1:0]  out_balance,
  output logic [sct_pkg::CASH_W-1:0]  out_highest,
  output logic                        out_liq
);
  import sct_pkg::*;

  localparam int CNT_W = $clog2(CASH_W);

  back_state_t state_r, state_nxt;

  cmd_t               cmd_r;
  logic [CASH_W-1:0]  dq_r;
  logic [PRICE_W-1:0] rem_r;
  logic [CASH_W-1:0]  acc_r;
  logic               ovf_r;
  logic [PRICE_W-1:0] mp_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SHARE_W-1:0] shares_r;
  logic [CASH_W-1:0]  cash_r, peak_r;
  logic               out_valid_r;
  logic [1:0]         out_action_r;
  logic [SHARE_W-1:0] out_shares_r;
  logic [CASH_W-1:0]  out_balance_r, out_highest_r;
  logic               out_liq_r;

  logic               take, load_out, div_last, mul_last;
  logic [PRICE_W:0]   rem_sh, rem_dn;
  logic               div_ge, capped;
  logic [CASH_W+1:0]  mul_sum;
  logic [CASH_W-1:0]  room;
  logic               sat;

  always_comb begin
    rem_sh  = {rem_r, dq_r[CASH_W-1]};
    div_ge  = rem_sh >= {1'b0, cmd_r.price};
    rem_dn  = div_ge ? (rem_sh - {1'b0, cmd_r.price}) : rem_sh;
    capped  = dq_r[CASH_W-1];
    mul_sum = {1'b0, acc_r, 1'b0}
            + (CASH_W + 2)'(mp_r[PRICE_W-1] ? shares_r : '0);
    room    = CASH_SAT - cash_r;
    sat     = ovf_r || (acc_r > room);
  end

  always_comb begin
    div_last = (cnt_r == CNT_W'(CASH_W - 1));
    mul_last = (cnt_r == CNT_W'(PRICE_W - 1));
    unique case (state_r)
      B_IDLE: begin
        priority if (cmd_empty) begin
          state_nxt = B_IDLE;
        end else if (cmd.action == ACT_BUY) begin
          state_nxt = B_DIV;
        end else if (cmd.action == ACT_SELL || cmd.liq) begin
          state_nxt = B_MUL;
        end else begin
          state_nxt = B_OUT;
        end
      end
      B_DIV:      state_nxt = div_last ? B_BUY_FIN : B_DIV;
      B_BUY_FIN:  state_nxt = cmd_r.liq ? B_MUL : B_OUT;
      B_MUL:      state_nxt = mul_last ? B_SELL_FIN : B_MUL;
      B_SELL_FIN: state_nxt = B_PEAK;
      B_PEAK:     state_nxt = B_OUT;
      B_OUT:      state_nxt = (!out_valid_r || out_ready) ? B_IDLE : B_OUT;
      default:    state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    take     = (state_r == B_IDLE) & ~cmd_empty;
    cmd_pop  = take;
    load_out = (state_r == B_OUT) & (~out_valid_r | out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      shares_r    <= '0;
      cash_r      <= '0;
      peak_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (bal_cfg.load) begin
        cash_r <= bal_cfg.value;
      end else if (state_r == B_BUY_FIN) begin
        cash_r <= capped ? (cash_r - CASH_W'(SHARE_MAX)) : CASH_W'(rem_r);
      end else if (state_r == B_SELL_FIN) begin
        cash_r <= sat ? CASH_SAT : (cash_r + acc_r);
      end
      if (state_r == B_BUY_FIN) begin
        shares_r <= capped ? SHARE_MAX : dq_r[SHARE_W-1:0];
      end else if (state_r == B_SELL_FIN) begin
        shares_r <= '0;
      end
      if (state_r == B_PEAK && cash_r > peak_r) begin
        peak_r <= cash_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd;
      dq_r  <= cash_r;
      rem_r <= '0;
      acc_r <= '0;
      ovf_r <= 1'b0;
      mp_r  <= cmd.price;
      cnt_r <= '0;
    end else if (state_r == B_DIV) begin
      rem_r <= rem_dn[PRICE_W-1:0];
      dq_r  <= {dq_r[CASH_W-2:0], div_ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (state_r == B_BUY_FIN) begin
      acc_r <= '0;
      ovf_r <= 1'b0;
      mp_r  <= cmd_r.price;
      cnt_r <= '0;
    end else if (state_r == B_MUL) begin
      acc_r <= mul_sum[CASH_W-1:0];
      ovf_r <= ovf_r | (mul_sum[CASH_W+1:CASH_W] != 2'b00);
      mp_r  <= {mp_r[PRICE_W-2:0], 1'b0};
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (load_out) begin
      out_action_r  <= cmd_r.action;
      out_liq_r     <= cmd_r.liq;
      out_shares_r  <= shares_r;
      out_balance_r <= cash_r;
      out_highest_r <= peak_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_action  = out_action_r;
  assign out_shares  = out_shares_r;
  assign out_balance = out_balance_r;
  assign out_highest = out_highest_r;
  assign out_liq     = out_liq_r;

endmodule
